// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/olc_pkg.sv =====
// Types, constants and codes of the one-time-code lock controller.
package olc_pkg;

  localparam int MODE_W   = 2;
  localparam int SAMPLE_W = 32;
  localparam int POT_W    = 12;
  localparam int SPAN_W   = 7;
  localparam int CODE_W   = 14;
  localparam int SECS_W   = 8;
  localparam int TRIES_W  = 3;
  localparam int SEED_W   = 31;
  localparam int STATUS_W = 4;

  localparam int POT_FULL_SCALE = 4095;

  localparam logic [SEED_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_INC = 31'd12345;

  localparam int CODE_MOD  = 9000;
  localparam int CODE_BASE = 1000;
  localparam int SECS_MAX  = 255;

  // Reciprocals scaled by 2^32; the quotient estimate is at most one low.
  localparam int RECIP_SH = 32;
  localparam longint unsigned RECIP_ONE  = 64'd1 << RECIP_SH;
  localparam longint unsigned SEED_RECIP = RECIP_ONE / CODE_MOD;
  localparam longint unsigned POT_RECIP  = RECIP_ONE / POT_FULL_SCALE;

  localparam int PV_W = POT_W + SPAN_W;
  localparam int QS_W = $clog2(((64'd1 << SEED_W) - 64'd1) / CODE_MOD + 64'd1);
  localparam int QP_W = $clog2(((2 ** POT_W - 1) * (2 ** SPAN_W - 1)) / POT_FULL_SCALE + 1);
  localparam int RS_W = $clog2(2 * CODE_MOD);
  localparam int RP_W = $clog2(2 * POT_FULL_SCALE);
  localparam int VSUM_W = QP_W + SECS_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_REQUEST = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_ENTRY   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOTHING   = 4'd0,
    ST_ISSUED    = 4'd1,
    ST_REISSUED  = 4'd2,
    ST_VALID     = 4'd3,
    ST_RETRY     = 4'd4,
    ST_LOCKED    = 4'd5,
    ST_EXPIRED   = 4'd6,
    ST_UNLOCKED  = 4'd7,
    ST_REFUSED   = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_WRONG       = 2'd0,
    CFG_LOCKOUT_SECONDS = 2'd1,
    CFG_BASE_VALIDITY   = 2'd2,
    CFG_VALIDITY_SPAN   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] seed_sample;
    logic [POT_W-1:0]    pot_value;
    logic [CODE_W-1:0]   entered_code;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   code_value;
    logic [SECS_W-1:0]   seconds_left;
    logic [TRIES_W-1:0]  tries_left;
    logic                green_on;
    logic                red_on;
    logic                buzzer_on;
  } out_item_t;

  typedef struct packed {
    logic [TRIES_W-1:0] max_wrong;
    logic [SECS_W-1:0]  lockout_seconds;
    logic [SECS_W-1:0]  base_validity;
    logic [SPAN_W-1:0]  validity_span;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              ack;
    logic [SEED_W-1:0] seed;
    logic [POT_W-1:0]  pot;
  } cg_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cg_stat_t;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [CODE_W-1:0] code;
    logic [SECS_W-1:0] validity;
  } cg_res_t;

endpackage

// ===== sv/otp_lock_controller.sv =====
// Top level of the one-time-code lock controller.
//
// Input channel in_*: one beat carries mode, seed sample, pot reading and
// entered code; it is taken when in_valid_i is high and in_stall_o is low.
// Output channel out_*: one result beat per input beat, in order, held in an
// output register until out_stall_i is low.
// Ticks, entries and requests that need no new code go from the input register
// to the result register; a new beat is taken every cycle unless out_stall_i
// holds the result register. A request that issues a new code waits for the
// generator, which runs an LCG multiply, a reciprocal multiply and a remainder
// step in that order, each registered, and the input stalls meanwhile.
// While the output register is stalled, one further beat is held in the
// input register; after that in_stall_o rises.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once;
// write only while no beat is in flight.
// Reset (rst_ni low) clears all lock state, empties both registers and
// restores the default configuration.
module otp_lock_controller import olc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t     cfg;
  cg_req_t  cg_req;
  cg_stat_t cg_stat;
  cg_res_t  cg_res;

  olc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  olc_codegen u_codegen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cg_req),
    .cfg_i  (cfg),
    .stat_o (cg_stat),
    .res_o  (cg_res)
  );

  olc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg),
    .cg_req_o    (cg_req),
    .cg_stat_i   (cg_stat),
    .cg_res_i    (cg_res)
  );

endmodule

// ===== sv/olc_cfg_regs.sv =====
// Configuration registers of the lock controller.
module olc_cfg_regs import olc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_wrong       <= 3'd3;
      cfg_q.lockout_seconds <= 8'd5;
      cfg_q.base_validity   <= 8'd60;
      cfg_q.validity_span   <= 7'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_WRONG:       cfg_q.max_wrong       <= cfg_wdata_i[TRIES_W-1:0];
        CFG_LOCKOUT_SECONDS: cfg_q.lockout_seconds <= cfg_wdata_i[SECS_W-1:0];
        CFG_BASE_VALIDITY:   cfg_q.base_validity   <= cfg_wdata_i[SECS_W-1:0];
        CFG_VALIDITY_SPAN:   cfg_q.validity_span   <= cfg_wdata_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/olc_codegen.sv =====
// Code and validity generator: LCG step, modulo 9000 and scaled validity.
module olc_codegen import olc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cg_req_t  req_i,
  input  cfg_t     cfg_i,
  output cg_stat_t stat_o,
  output cg_res_t  res_o
);

  typedef enum logic [1:0] {
    CG_IDLE,
    CG_RECIP,
    CG_REM,
    CG_DONE
  } cg_state_e;

  cg_state_e state_q;

  logic [SEED_W-1:0] lcg_q;
  logic [PV_W-1:0]   pv_q;
  logic [QS_W-1:0]   qs_q;
  logic [QP_W-1:0]   qp_q;
  logic [RS_W-1:0]   rs_q;
  logic [RP_W-1:0]   rp_q;

  logic [SEED_W-1:0]      lcg_d;
  logic [PV_W-1:0]        pv_d;
  logic [SEED_W+31:0]     qs_prod;
  logic [PV_W+31:0]       qp_prod;
  logic [SEED_W-1:0]      rs_full;
  logic [PV_W-1:0]        rp_full;
  logic [RS_W-1:0]        rs_fix;
  logic [QP_W:0]          valp;
  logic [VSUM_W-1:0]      vsum;

  assign lcg_d   = req_i.seed * LCG_MUL + LCG_INC;
  assign pv_d    = PV_W'(req_i.pot) * PV_W'(cfg_i.validity_span);
  assign qs_prod = (SEED_W+32)'(lcg_q) * (SEED_W+32)'(SEED_RECIP);
  assign qp_prod = (PV_W+32)'(pv_q) * (PV_W+32)'(POT_RECIP);
  assign rs_full = lcg_q - SEED_W'(qs_q) * SEED_W'(CODE_MOD);
  assign rp_full = pv_q - PV_W'(qp_q) * PV_W'(POT_FULL_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CG_IDLE;
    end else begin
      case (state_q)
        CG_IDLE:  if (req_i.start) state_q <= CG_RECIP;
        CG_RECIP: state_q <= CG_REM;
        CG_REM:   state_q <= CG_DONE;
        CG_DONE:  if (req_i.ack) state_q <= CG_IDLE;
        default:  state_q <= CG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CG_IDLE && req_i.start) begin
      lcg_q <= lcg_d;
      pv_q  <= pv_d;
    end
    if (state_q == CG_RECIP) begin
      qs_q <= qs_prod[RECIP_SH +: QS_W];
      qp_q <= qp_prod[RECIP_SH +: QP_W];
    end
    if (state_q == CG_REM) begin
      rs_q <= rs_full[RS_W-1:0];
      rp_q <= rp_full[RP_W-1:0];
    end
  end

  always_comb begin
    rs_fix = (rs_q >= RS_W'(CODE_MOD)) ? rs_q - RS_W'(CODE_MOD) : rs_q;
    valp   = (QP_W+1)'(qp_q) + (QP_W+1)'(rp_q >= RP_W'(POT_FULL_SCALE));
    vsum   = VSUM_W'(cfg_i.base_validity) + VSUM_W'(valp);
    res_o.seed     = lcg_q;
    res_o.code     = CODE_W'(rs_fix) + CODE_W'(CODE_BASE);
    res_o.validity = (vsum > VSUM_W'(SECS_MAX)) ? SECS_W'(SECS_MAX) : vsum[SECS_W-1:0];
  end

  assign stat_o.busy = (state_q == CG_RECIP) || (state_q == CG_REM);
  assign stat_o.done = (state_q == CG_DONE);

endmodule

// ===== sv/olc_core.sv =====
// Input register, lock state update and result register.
module olc_core import olc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  cfg_t      cfg_i,
  output cg_req_t   cg_req_o,
  input  cg_stat_t  cg_stat_i,
  input  cg_res_t   cg_res_i
);

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;

  logic [SEED_W-1:0]  seed_q,     seed_d;
  logic               loaded_q,   loaded_d;
  logic [CODE_W-1:0]  active_q,   active_d;
  logic               live_q,     live_d;
  logic [SECS_W-1:0]  valid_q,    valid_d;
  logic [TRIES_W-1:0] wrong_q,    wrong_d;
  logic               locked_q,   locked_d;
  logic [SECS_W-1:0]  lock_q,     lock_d;
  logic               green_q,    green_d;
  logic               red_q,      red_d;
  logic               buzz_q,     buzz_d;

  logic               slot_free;
  logic               needs_gen;
  logic               fin;
  logic [TRIES_W-1:0] wrong_inc;
  out_item_t          res;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign needs_gen = in_vld_q && (in_q.mode == MODE_REQUEST) && !locked_q && !live_q;
  assign fin       = in_vld_q && (!needs_gen || cg_stat_i.done) && slot_free;
  assign in_stall_o = in_vld_q && !fin;

  assign cg_req_o.start = needs_gen && !cg_stat_i.busy && !cg_stat_i.done;
  assign cg_req_o.ack   = fin && needs_gen;
  assign cg_req_o.seed  = loaded_q ? seed_q : in_q.seed_sample[SEED_W-1:0];
  assign cg_req_o.pot   = in_q.pot_value;

  assign wrong_inc = wrong_q + TRIES_W'(1);

  always_comb begin
    seed_d   = seed_q;
    loaded_d = loaded_q;
    active_d = active_q;
    live_d   = live_q;
    valid_d  = valid_q;
    wrong_d  = wrong_q;
    locked_d = locked_q;
    lock_d   = lock_q;
    green_d  = green_q;
    red_d    = red_q;
    buzz_d   = buzz_q;
    res      = '0;
    res.status = ST_NOTHING;
    case (in_q.mode)
      MODE_REQUEST: begin
        if (locked_q) begin
          res.status = ST_REFUSED;
        end else if (live_q) begin
          res.status     = ST_REISSUED;
          res.code_value = active_q;
        end else begin
          seed_d         = cg_res_i.seed;
          loaded_d       = 1'b1;
          active_d       = cg_res_i.code;
          live_d         = 1'b1;
          valid_d        = cg_res_i.validity;
          res.status     = ST_ISSUED;
          res.code_value = cg_res_i.code;
        end
      end
      MODE_TICK: begin
        if (locked_q) begin
          if (lock_q != '0) begin
            lock_d = lock_q - SECS_W'(1);
          end else begin
            locked_d   = 1'b0;
            wrong_d    = '0;
            red_d      = 1'b0;
            buzz_d     = 1'b0;
            res.status = ST_UNLOCKED;
          end
        end else if (live_q) begin
          if (valid_q != '0) begin
            valid_d = valid_q - SECS_W'(1);
          end else begin
            live_d     = 1'b0;
            active_d   = '0;
            res.status = ST_EXPIRED;
          end
        end
      end
      MODE_ENTRY: begin
        if (live_q) begin
          if (in_q.entered_code == active_q) begin
            green_d    = 1'b1;
            red_d      = 1'b0;
            buzz_d     = 1'b0;
            live_d     = 1'b0;
            wrong_d    = '0;
            res.status = ST_VALID;
          end else begin
            red_d   = 1'b1;
            green_d = 1'b0;
            if (wrong_inc < cfg_i.max_wrong) begin
              wrong_d    = wrong_inc;
              res.status = ST_RETRY;
            end else begin
              locked_d   = 1'b1;
              lock_d     = cfg_i.lockout_seconds;
              buzz_d     = 1'b1;
              live_d     = 1'b0;
              wrong_d    = '0;
              res.status = ST_LOCKED;
            end
          end
        end
      end
      default: ;
    endcase
    res.seconds_left = locked_d ? lock_d : (live_d ? valid_d : '0);
    res.tries_left   = (locked_d || wrong_d >= cfg_i.max_wrong) ? '0
                                                                : cfg_i.max_wrong - wrong_d;
    res.green_on  = green_d;
    res.red_on    = red_d;
    res.buzzer_on = buzz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      seed_q    <= '0;
      loaded_q  <= 1'b0;
      active_q  <= '0;
      live_q    <= 1'b0;
      valid_q   <= '0;
      wrong_q   <= '0;
      locked_q  <= 1'b0;
      lock_q    <= '0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      buzz_q    <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (fin) begin
        in_vld_q <= 1'b0;
      end
      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (fin) begin
        seed_q   <= seed_d;
        loaded_q <= loaded_d;
        active_q <= active_d;
        live_q   <= live_d;
        valid_q  <= valid_d;
        wrong_q  <= wrong_d;
        locked_q <= locked_d;
        lock_q   <= lock_d;
        green_q  <= green_d;
        red_q    <= red_d;
        buzz_q   <= buzz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fin) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/olc_checker.sv =====
// Port-level assertions for the lock controller and their bind.
`include "assert_macros.svh"

module olc_checker import olc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic held_beat;
  logic code_beat;
  logic code_in_range;
  logic buzz_beat;
  logic buzz_ok;
  logic lock_beat;
  logic lock_ok;

  assign held_beat     = out_valid_o && out_stall_i;
  assign code_beat     = out_valid_o && (out_data_o.status == ST_ISSUED ||
                                         out_data_o.status == ST_REISSUED);
  assign code_in_range = out_data_o.code_value >= 14'd1000 && out_data_o.code_value <= 14'd9999;
  assign buzz_beat     = out_valid_o && out_data_o.buzzer_on;
  assign buzz_ok       = out_data_o.tries_left == 3'd0 && !out_data_o.green_on;
  assign lock_beat     = out_valid_o && out_data_o.status == ST_LOCKED;
  assign lock_ok       = out_data_o.buzzer_on && out_data_o.red_on &&
                         out_data_o.code_value == 14'd0;

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, held_beat |=> out_valid_o && $stable(out_data_o))

  `ASSERT_CLK(a_code_range, clk_i, rst_ni, code_beat |-> code_in_range)

  `ASSERT_CLK(a_buzzer_locked, clk_i, rst_ni, buzz_beat |-> buzz_ok)

  `ASSERT_CLK(a_lockout, clk_i, rst_ni, lock_beat |-> lock_ok)

  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind otp_lock_controller olc_checker u_olc_checker (.*);
